// ===== rtl/core/ncra_pkg.sv =====
// Shared constants and types of the name cache ring allocator.
`default_nettype none

package ncra_pkg;

    // Sizing of the slot ring and of the name buffer.
    localparam int ENTRIES      = 64;
    localparam int BUFFER_BYTES = 8192;
    localparam int MAX_NAME     = 256;

    localparam int SLOT_W    = $clog2(ENTRIES);
    localparam int POS_W     = $clog2(BUFFER_BYTES);
    localparam int SUM_W     = POS_W + 1;
    localparam int CLUSTER_W = 32;
    localparam int INDEX_W   = 16;
    localparam int LEN_W     = 8;

    // Result fields have fixed widths on the stream port.
    localparam int OUT_POS_W   = 13;
    localparam int OUT_EVICT_W = 6;

    // Highest position a new name may start at.
    localparam int LIMIT = BUFFER_BYTES - MAX_NAME;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [INDEX_W-1:0]   index;
        logic [POS_W-1:0]     pos;
        logic [LEN_W-1:0]     len;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Flags and placement computed by the shared compare unit.
    typedef struct packed {
        logic             key_match;
        logic             in_window;
        logic [POS_W-1:0] next_pos;
    } t_cmp_res;

endpackage

`default_nettype wire

// ===== rtl/core/ncra_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ncra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/ncra_cmp.sv =====
// Shared compare unit: key match, eviction window test and next placement.
`default_nettype none

module ncra_cmp (
    input  wire ncra_pkg::t_entry                   i_entry,
    input  wire logic [ncra_pkg::CLUSTER_W-1:0]     i_cluster,
    input  wire logic [ncra_pkg::INDEX_W-1:0]       i_index,
    input  wire logic [ncra_pkg::POS_W-1:0]         i_base,
    output ncra_pkg::t_cmp_res                      o_res
);
    import ncra_pkg::*;

    logic [SUM_W-1:0] entry_pos;
    logic [SUM_W-1:0] base_ext;
    logic [SUM_W-1:0] window_end;
    logic [SUM_W-1:0] sum;

    always_comb begin
        entry_pos  = SUM_W'(i_entry.pos);
        base_ext   = SUM_W'(i_base);
        window_end = base_ext + SUM_W'(MAX_NAME);
        // The new name goes one terminator byte after this entry's name.
        sum        = entry_pos + SUM_W'(i_entry.len) + SUM_W'(1);

        o_res.key_match = (i_entry.cluster == i_cluster) && (i_entry.index == i_index);
        o_res.in_window = (entry_pos >= base_ext) && (entry_pos < window_end);
        o_res.next_pos  = (sum > SUM_W'(LIMIT)) ? '0 : sum[POS_W-1:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/name_cache_ring_allocator.sv =====
// Top level of the name cache ring allocator: sequencer, slot RAM and result register.
// A hit scans the live slots from the oldest up to the matching one, then goes to ST_FIN.
// A miss scans every live slot, evicts in ST_EVICT, then goes to ST_FIN (empty ring: straight to ST_FIN).
// Throughput: one transaction at a time; the slot scan reads one RAM entry per cycle.
// Reset: synchronous, active low; clears the ring pointers and handshakes, RAM is not cleared.
`default_nettype none

module name_cache_ring_allocator (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // Fields from bit 0: dir_cluster[31:0], file_index[47:32], name_length[55:48].
    input  wire logic [55:0] i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // Fields from bit 0: position[12:0], evicted_count[18:13], zero fill above.
    output logic [23:0]      o_m_axis_tdata,
    // Fields from bit 0: hit.
    output logic             o_m_axis_tuser
);
    import ncra_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVICT,
        ST_FIN
    } t_state;

    t_state                 r_state;
    logic [SLOT_W-1:0]      r_oldest;
    logic [SLOT_W-1:0]      r_next_free;
    logic [SLOT_W-1:0]      r_ptr;
    logic [CLUSTER_W-1:0]   r_cluster;
    logic [INDEX_W-1:0]     r_index;
    logic [LEN_W-1:0]       r_len;
    logic [POS_W-1:0]       r_pos;
    logic                   r_hit;
    logic [OUT_EVICT_W-1:0] r_evicted;

    logic                   r_m_tvalid;
    logic                   r_m_hit;
    logic [OUT_POS_W-1:0]   r_m_pos;
    logic [OUT_EVICT_W-1:0] r_m_evicted;

    logic [SLOT_W-1:0]      rd_addr;
    t_entry                 rd_entry;
    t_entry                 wr_entry;
    logic                   wr_en;
    t_cmp_res               cmp;
    logic                   out_free;
    logic                   accept;
    logic [SLOT_W-1:0]      ptr_next;
    logic [SLOT_W-1:0]      oldest_next;
    logic [SLOT_W-1:0]      free_next;

    // Ring successor; the ring size need not be a power of two.
    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(ENTRIES - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign out_free        = !r_m_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign ptr_next        = ring_next(r_ptr);
    assign oldest_next     = ring_next(r_oldest);
    assign free_next       = ring_next(r_next_free);

    // The read address is chosen in the cycle before the state that consumes the data.
    always_comb begin
        rd_addr = r_ptr;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr = r_oldest;
            end
            ST_SCAN: begin
                if (!cmp.key_match && ptr_next == r_next_free) begin
                    rd_addr = r_oldest;
                end else begin
                    rd_addr = ptr_next;
                end
            end
            ST_EVICT: begin
                rd_addr = oldest_next;
            end
            ST_FIN: begin
                rd_addr = r_oldest;
            end
            default: begin
                rd_addr = r_ptr;
            end
        endcase
    end

    // A new entry is recorded when a miss result leaves for the output register.
    assign wr_en          = (r_state == ST_FIN) && !r_hit && out_free;
    assign wr_entry.cluster = r_cluster;
    assign wr_entry.index   = r_index;
    assign wr_entry.pos     = r_pos;
    assign wr_entry.len     = r_len;

    ncra_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_next_free),
        .i_wdata (wr_entry),
        .i_raddr (rd_addr),
        .o_rdata (rd_entry)
    );

    // One compare unit serves the key scan, the placement and the window test.
    ncra_cmp u_cmp (
        .i_entry   (rd_entry),
        .i_cluster (r_cluster),
        .i_index   (r_index),
        .i_base    (r_pos),
        .o_res     (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_next_free <= '0;
            r_m_tvalid  <= 1'b0;
        end else begin
            // In ST_FIN the output register is either held or reloaded below.
            if (i_m_axis_tready && r_state != ST_FIN) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cluster <= i_s_axis_tdata[31:0];
                        r_index   <= i_s_axis_tdata[47:32];
                        r_len     <= i_s_axis_tdata[55:48];
                        r_hit     <= 1'b0;
                        r_evicted <= '0;
                        r_ptr     <= r_oldest;
                        if (r_oldest == r_next_free) begin
                            // Empty ring: the name starts the buffer, nothing to drop.
                            r_pos   <= '0;
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (cmp.key_match) begin
                        r_hit   <= 1'b1;
                        r_pos   <= rd_entry.pos;
                        r_state <= ST_FIN;
                    end else if (ptr_next == r_next_free) begin
                        // The last slot scanned is the newest one; place after its name.
                        r_pos   <= cmp.next_pos;
                        r_state <= ST_EVICT;
                    end else begin
                        r_ptr <= ptr_next;
                    end
                end
                ST_EVICT: begin
                    if (r_oldest != r_next_free && cmp.in_window) begin
                        r_oldest  <= oldest_next;
                        r_evicted <= r_evicted + OUT_EVICT_W'(1);
                    end else begin
                        // A full ring gives up its oldest slot to the new entry.
                        if (r_oldest == free_next) begin
                            r_oldest  <= oldest_next;
                            r_evicted <= r_evicted + OUT_EVICT_W'(1);
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_m_tvalid  <= 1'b1;
                        r_m_hit     <= r_hit;
                        r_m_pos     <= OUT_POS_W'(r_pos);
                        r_m_evicted <= r_evicted;
                        if (!r_hit) begin
                            r_next_free <= free_next;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {5'b0, r_m_evicted, r_m_pos};
    assign o_m_axis_tuser  = r_m_hit;

    // A hit never drops entries.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_tvalid && r_m_hit) |-> (r_m_evicted == '0))
        else $error("hit result reports evictions");

    // Recording a miss never makes the ring look empty.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_next_free != r_oldest))
        else $error("ring overflow after allocation");

    // The oldest pointer moves only while evicting.
    a_oldest_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_SCAN) |=> (r_oldest == $past(r_oldest)))
        else $error("oldest slot moved outside eviction");

    // A placement never starts past the last window that fits.
    a_pos_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && !r_hit) |-> (SUM_W'(r_pos) <= SUM_W'(LIMIT)))
        else $error("placement beyond buffer limit");

endmodule

`default_nettype wire
